[rtl/dmcg_pkg.sv]
`default_nettype none
package dmcg_pkg;

  localparam int RADIUS_DEF    = 15;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int STORE_ROWS    = 32;
  localparam int ROW_SLOT_W    = 5;
  localparam int PIX_W         = 8;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 10;
  localparam int COUNT_W       = 21;
  localparam int SUM_W         = 18;   // 961 points * 255 fits
  localparam int CNT_W         = 10;   // up to 961 points
  localparam int HALF_W        = 4;
  localparam int XW            = 13;   // signed scan position

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOW_THRESH  = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [PIX_W-1:0] GLOW_THRESH_RST  = 8'd20;
  localparam logic [PIX_W-1:0] PIX_SAT          = 8'd255;

  typedef struct packed {
    logic             flush;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [ROW_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_done;
  } out_t;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic scan_last;
    logic div_last;
  } sts_t;

  // half width of the disk per row offset, 4 bits per entry
  function automatic logic [16*HALF_W-1:0] half_tab(input int r);
    logic [16*HALF_W-1:0] t;
    int a;
    int k;
    t = '0;
    for (a = 0; a < 16; a++) begin
      for (k = 0; k < 16; k++) begin
        if (a <= r && k * k + a * a <= r * r) t[a*HALF_W +: HALF_W] = HALF_W'(k);
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/dmcg_ctrl.sv]
`default_nettype none
module dmcg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  dmcg_pkg::sts_t      sts,
  output dmcg_pkg::cmd_t      cmd
);
  import dmcg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_SCAN, S_DRAIN, S_DINIT, S_DIV, S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.ready) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DINIT;
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/dmcg_datapath.sv]
`default_nettype none
module dmcg_datapath #(
  parameter int RADIUS    = dmcg_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = dmcg_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [dmcg_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [dmcg_pkg::CFG_W-1:0]        cfg_wdata,
  input  dmcg_pkg::in_t                          in_data,
  input  dmcg_pkg::cmd_t                         cmd,
  output dmcg_pkg::sts_t                         sts,
  output dmcg_pkg::out_t                         out_data
);
  import dmcg_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [16*HALF_W-1:0] HALF = half_tab(RADIUS);
  localparam logic [HALF_W-1:0] HALF_R = HALF[RADIUS*HALF_W +: HALF_W];

  // configuration
  logic [CFG_W-1:0] fw_r, fh_r;
  logic [PIX_W-1:0] thr_r;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic             restart;

  // frame counters
  logic [COUNT_W-1:0] arrived_r, emit_idx_r;
  logic [CW-1:0]      arr_col_r, emit_col_r;
  logic [ROW_W-1:0]   arr_row_r, emit_row_r;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W:0]   need;
  logic               store_px, frame_done;

  // scan
  logic signed [4:0]    dy_r, dx_r;
  logic [HALF_W-1:0]    ady, ady_n, hw, hw_n;
  logic signed [4:0]    dy_n;
  logic signed [XW-1:0] xp, yp;
  logic                 inframe, is_ctr;

  // store
  logic [3*PIX_W-1:0] mem [STORE_ROWS][MAX_WIDTH];
  logic [3*PIX_W-1:0] mem_q;
  logic               rd_vld_r, rd_ctr_r;

  // accumulate and divide
  logic [SUM_W-1:0] sum_r [3];
  logic [CNT_W-1:0] cnt_r;
  logic [PIX_W-1:0] ctr_r [3];
  logic [SUM_W-1:0] q_r [3];
  logic [CNT_W-1:0] rem_r [3];
  logic [4:0]       div_cnt_r;
  logic [PIX_W-1:0] res [3];

  assign eff_w = (fw_r == '0) ? CFG_W'(1) :
                 (fw_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : fw_r;
  assign eff_h = (fh_r == '0) ? CFG_W'(1) :
                 (fh_r > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : fh_r;
  assign restart = cfg_we && (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT);

  assign total    = COUNT_W'(eff_w) * COUNT_W'(eff_h);
  assign need     = (COUNT_W+1)'(emit_idx_r) + (COUNT_W+1)'(RADIUS) * (COUNT_W+1)'(eff_w)
                  + (COUNT_W+1)'(RADIUS);
  assign store_px = cmd.accept && !in_data.flush && (arrived_r < total);
  assign sts.ready = ((COUNT_W+1)'(arrived_r) > need) || (arrived_r >= total);
  assign frame_done = (CFG_W'(emit_col_r) + 1'b1 >= eff_w) &&
                      (CFG_W'(emit_row_r) + 1'b1 >= eff_h);

  always_comb begin
    ady   = dy_r[4] ? HALF_W'(-dy_r) : HALF_W'(dy_r);
    hw    = HALF[ady*HALF_W +: HALF_W];
    dy_n  = dy_r + 5'sd1;
    ady_n = dy_n[4] ? HALF_W'(-dy_n) : HALF_W'(dy_n);
    hw_n  = HALF[ady_n*HALF_W +: HALF_W];
    xp    = $signed(XW'(emit_col_r)) + XW'(dx_r);
    yp    = $signed(XW'(emit_row_r)) + XW'(dy_r);
    inframe = !xp[XW-1] && !yp[XW-1] && (xp < $signed(XW'(eff_w))) &&
              (yp < $signed(XW'(eff_h)));
    is_ctr  = (dx_r == 5'sd0) && (dy_r == 5'sd0);
  end

  assign sts.scan_last = (dy_r == 5'(RADIUS)) && (dx_r == $signed({1'b0, hw}));
  assign sts.div_last  = (div_cnt_r == 5'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= FRAME_WIDTH_RST;
      fh_r  <= FRAME_HEIGHT_RST;
      thr_r <= GLOW_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_r  <= cfg_wdata;
        REG_GLOW_THRESH:  thr_r <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart || (cmd.emit && frame_done)) begin
      arrived_r  <= '0;
      arr_col_r  <= '0;
      arr_row_r  <= '0;
      emit_idx_r <= '0;
      emit_col_r <= '0;
      emit_row_r <= '0;
    end else begin
      if (store_px) begin
        arrived_r <= arrived_r + 1'b1;
        if (CFG_W'(arr_col_r) + 1'b1 >= eff_w) begin
          arr_col_r <= '0;
          arr_row_r <= arr_row_r + 1'b1;
        end else begin
          arr_col_r <= arr_col_r + 1'b1;
        end
      end
      if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + 1'b1;
        if (CFG_W'(emit_col_r) + 1'b1 >= eff_w) begin
          emit_col_r <= '0;
          emit_row_r <= emit_row_r + 1'b1;
        end else begin
          emit_col_r <= emit_col_r + 1'b1;
        end
      end
    end
  end

  // pixel store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_px) begin
      mem[arr_row_r[ROW_SLOT_W-1:0]][arr_col_r] <=
        {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    mem_q <= mem[yp[ROW_SLOT_W-1:0]][xp[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_ctr_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step && inframe;
      rd_ctr_r <= cmd.scan_step && inframe && is_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      dy_r <= 5'(-RADIUS);
      dx_r <= -$signed({1'b0, HALF_R});
    end else if (cmd.scan_step) begin
      if (dx_r == $signed({1'b0, hw})) begin
        dy_r <= dy_n;
        dx_r <= -$signed({1'b0, hw_n});
      end else begin
        dx_r <= dx_r + 5'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cnt_r <= '0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else if (rd_vld_r) begin
      cnt_r <= cnt_r + 1'b1;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= sum_r[i] + SUM_W'(mem_q[(2-i)*PIX_W +: PIX_W]);
      end
    end
    if (rd_ctr_r) begin
      for (int i = 0; i < 3; i++) ctr_r[i] <= mem_q[(2-i)*PIX_W +: PIX_W];
    end
  end

  // restoring divide, one quotient bit per step, three channels side by side
  always_ff @(posedge clk) begin
    logic [CNT_W:0] t;
    if (cmd.div_init) begin
      div_cnt_r <= '0;
      for (int i = 0; i < 3; i++) begin
        q_r[i]   <= sum_r[i];
        rem_r[i] <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      for (int i = 0; i < 3; i++) begin
        t = {rem_r[i], q_r[i][SUM_W-1]};
        if (t >= (CNT_W+1)'(cnt_r)) begin
          rem_r[i] <= CNT_W'(t - (CNT_W+1)'(cnt_r));
          q_r[i]   <= {q_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= CNT_W'(t);
          q_r[i]   <= {q_r[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = (q_r[i][PIX_W-1:0] > ctr_r[i]) ? q_r[i][PIX_W-1:0] - ctr_r[i] : '0;
      if (res[i] > thr_r) res[i] = PIX_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.red_out    <= res[0];
      out_data.green_out  <= res[1];
      out_data.blue_out   <= res[2];
      out_data.out_col    <= ROW_W'(emit_col_r);
      out_data.out_row    <= emit_row_r;
      out_data.frame_done <= frame_done;
    end
  end

  a_arrived_bound: assert property (@(posedge clk) disable iff (!rst_n)
    arrived_r <= total) else $error("arrived count beyond frame");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_idx_r < total) else $error("emit index beyond frame");
  a_ctr_inframe: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctr_r |-> rd_vld_r) else $error("centre read outside frame");
  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_init |-> sts.ready) else $error("scan started without ready result");

endmodule
`default_nettype wire

[rtl/disk_mean_contrast_glow_filter.sv]
`default_nettype none
// Disk-mean contrast glow filter. RGB pixels enter in raster order and are
// kept in a 32-row store; each result is, per channel, the floor mean of the
// in-frame pixels within radius RADIUS, minus the centre, clamped at 0 and
// forced to 255 above glow_threshold. Results trail the input by RADIUS rows
// plus RADIUS pixels; flush transactions drain the tail of a frame. For an
// item that yields a result the disk of N points (709 at radius 15) is
// scanned one store read a cycle through the single read port, then an
// 18-step divide runs for all three channels at once. One item is worked
// at a time; the output register holds a result while the next transaction
// is taken. No clearing pass after reset.
module disk_mean_contrast_glow_filter #(
  parameter int RADIUS    = dmcg_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = dmcg_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dmcg_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [dmcg_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  dmcg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output dmcg_pkg::out_t                      out_data
);
  import dmcg_pkg::*;

  cmd_t cmd;   // controller -> datapath
  sts_t sts;   // datapath -> controller

  dmcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmcg_datapath #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[bench/glow_filter_checker.sv]
`timescale 1ns / 1ps
module glow_filter_checker
  import dmcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   frames_done,
  output int                   results_seen
);

  localparam int R = RADIUS_DEF;

  logic [CFG_W-1:0] width_reg, height_reg;
  logic [PIX_W-1:0] thresh_reg;
  logic [23:0]      pix_mem [0:STORE_ROWS*MAX_WIDTH_DEF-1];
  int unsigned      arrived, emit_c, emit_r;
  out_t             expected_px [$];

  function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned slot(input int unsigned row, input int unsigned col);
    return (row % STORE_ROWS) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF);
  endfunction

  function automatic logic [PIX_W-1:0] glow(input int unsigned s, input int unsigned n,
                                            input int unsigned centre);
    int unsigned m, d;
    m = s / n;
    d = (m > centre) ? m - centre : 0;
    if (d > thresh_reg) d = 255;
    return d[PIX_W-1:0];
  endfunction

  // One accepted transaction: store pixel, then maybe emit the next result.
  task automatic step_filter(input in_t d);
    int unsigned w, h, total, need, sr, sg, sb, cnt;
    int x, y;
    logic [23:0] p, c;
    out_t r;
    w = sat_dim(width_reg, MAX_WIDTH_DEF);
    h = sat_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    if (!d.flush && arrived < total) begin
      pix_mem[slot(arrived / w, arrived % w)] = {d.red_in, d.green_in, d.blue_in};
      arrived++;
    end
    need = (emit_r * w + emit_c) + R * w + R;
    if (!(arrived > need || arrived >= total)) return;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dy = -R; dy <= R; dy++) begin
      for (int dx = -R; dx <= R; dx++) begin
        x = int'(emit_c) + dx;
        y = int'(emit_r) + dy;
        if (dx * dx + dy * dy > R * R) continue;
        if (x < 0 || y < 0 || x >= int'(w) || y >= int'(h)) continue;
        p = pix_mem[slot(y, x)];
        sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    c = pix_mem[slot(emit_r, emit_c)];
    r.red_out    = glow(sr, cnt, c[23:16]);
    r.green_out  = glow(sg, cnt, c[15:8]);
    r.blue_out   = glow(sb, cnt, c[7:0]);
    r.out_col    = emit_c[ROW_W-1:0];
    r.out_row    = emit_r[ROW_W-1:0];
    r.frame_done = (emit_c + 1 >= w) && (emit_r + 1 >= h);
    expected_px.insert(expected_px.size(), r);
    if (r.frame_done) begin
      arrived = 0; emit_c = 0; emit_r = 0;
    end else if (emit_c + 1 >= w) begin
      emit_c = 0; emit_r++;
    end else begin
      emit_c++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      width_reg = FRAME_WIDTH_RST; height_reg = FRAME_HEIGHT_RST;
      thresh_reg = GLOW_THRESH_RST;
      arrived = 0; emit_c = 0; emit_r = 0;
      expected_px.delete();
      fail_count = 0; frames_done = 0; results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_wdata; arrived = 0; emit_c = 0; emit_r = 0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_wdata; arrived = 0; emit_c = 0; emit_r = 0;
          end
          REG_GLOW_THRESH: thresh_reg = cfg_wdata[PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) step_filter(in_data);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.frame_done) frames_done++;
        if (expected_px.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result transaction %p", $realtime, out_data);
        end else begin
          want = expected_px.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: expected %p, got %p", $realtime, want, out_data);
          end
        end
      end
    end
    pending = expected_px.size();
  end

endmodule

[bench/disk_mean_contrast_glow_filter_tb.sv]
`timescale 1ns / 1ps
module disk_mean_contrast_glow_filter_tb;
  import dmcg_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;

  int fail_count, pending, frames_done, results_seen;
  int items_sent;
  int idle_mode;   // 0: sender light / receiver heavy, 1: swapped, 2: no idling
  int frame_count;

  disk_mean_contrast_glow_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  glow_filter_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending),
    .frames_done(frames_done), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: slowest run is ~1250 results, each a full disk scan and divide, plus stalls.
  initial begin
    #60ms;
    $display("timeout: %0d items, %0d results, %0d pending", items_sent, results_seen,
             pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver side. One long hold-off once results are flowing, so the block
  // fills up and stalls its input while the sender keeps offering.
  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && results_seen >= 40) begin
        held_once = 1;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (idle_mode)
          0:       out_stall <= ($urandom_range(99) < 57);
          1:       out_stall <= ($urandom_range(99) < 9);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  function automatic bit sender_idles();
    case (idle_mode)
      0:       return $urandom_range(99) < 9;
      1:       return $urandom_range(99) < 57;
      default: return 0;
    endcase
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high into
  // the next call unless that call decides to idle first.
  task automatic send_item(input in_t d);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    idle_mode = (items_sent < 420) ? 0 : (items_sent < 840) ? 1 : 2;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_t d;
    d.flush = 1'b0; d.red_in = r; d.green_in = g; d.blue_in = b;
    send_item(d);
  endtask

  task automatic send_flush();
    in_t d;
    d = in_t'($urandom);
    d.flush = 1'b1;
    send_item(d);
  endtask

  task automatic send_random_pixel();
    in_t d;
    d = in_t'($urandom);
    d.flush = 1'b0;
    send_item(d);
  endtask

  // Block idle: nothing expected, then a wait for any no-result transaction
  // still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Consecutive writes keep cfg_we high; caller ends the burst with cfg_end.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic cfg_end();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Keep offering flushes (sometimes dropped pixels) until the frame closes.
  task automatic drain_frame(input int done_before);
    while (frames_done == done_before) begin
      if ($urandom_range(99) < 30) send_random_pixel();
      else send_flush();
    end
  endtask

  task automatic run_frame(input int w, input int h, input int noise_pct);
    int fd0;
    fd0 = frames_done;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) send_flush();
      send_random_pixel();
    end
    drain_frame(fd0);
    frame_count++;
  endtask

  initial begin
    int w, h, fd0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_data = '0;
    rst_n = 1'b0;
    items_sent = 0; idle_mode = 0; frame_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flush with nothing ready at reset geometry.
    send_flush();
    wait_idle();

    // Zero width/height saturate to a 1x1 frame; threshold 0.
    cfg_write(REG_FRAME_WIDTH, '0);
    cfg_write(REG_FRAME_HEIGHT, '0);
    cfg_write(REG_GLOW_THRESH, '0);
    cfg_end();
    fd0 = frames_done;
    send_pixel(8'hff, 8'h00, 8'hff);
    drain_frame(fd0);
    wait_idle();

    // Oversize width saturates to the maximum; a partial frame emits nothing
    // and the next geometry write restarts it.
    cfg_write(REG_FRAME_WIDTH, '1);
    cfg_write(REG_FRAME_HEIGHT, 11'd1);
    cfg_write(REG_GLOW_THRESH, 11'd255);
    cfg_end();
    for (int i = 0; i < 6; i++) send_pixel(i[0] ? 8'hff : 8'h00, 8'h80, 8'h7f);
    wait_idle();
    cfg_write(REG_FRAME_HEIGHT, '1);
    cfg_write(2'd3, '1);   // unmapped index, ignored
    cfg_end();
    for (int i = 0; i < 3; i++) send_pixel(8'h00, 8'hff, 8'h00);
    wait_idle();

    // Small frame with extreme pixels and a mid-range threshold.
    cfg_write(REG_FRAME_WIDTH, 11'd3);
    cfg_write(REG_FRAME_HEIGHT, 11'd2);
    cfg_write(REG_GLOW_THRESH, 11'd20);
    cfg_end();
    fd0 = frames_done;
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_flush();
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h10, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h30);
    drain_frame(fd0);
    wait_idle();

    // Random frames, mostly small. Each phase reprograms all registers.
    while (items_sent < 1250) begin
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(30, 40); h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 16); h = $urandom_range(1, 16);
      end
      cfg_write(REG_FRAME_WIDTH, CFG_W'(w));
      cfg_write(REG_FRAME_HEIGHT, CFG_W'(h));
      case ($urandom_range(3))
        0:       cfg_write(REG_GLOW_THRESH, 11'd0);
        1:       cfg_write(REG_GLOW_THRESH, 11'd255);
        default: cfg_write(REG_GLOW_THRESH, CFG_W'($urandom_range(255)));
      endcase
      cfg_end();
      run_frame(w, h, 5);
      // Back-to-back frame without reprogramming now and then.
      if ($urandom_range(3) == 0) run_frame(w, h, 5);
      wait_idle();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d transactions over %0d frames, %0d filtered pixels checked,",
             items_sent, frame_count, results_seen);
    $display("with saturated geometry, threshold extremes, flush and dropped-pixel drains.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
